// ===== hdl/rtm_pkg.sv =====
// shared types and constants for the radial tukey mask unit
package rtm_pkg;

    localparam int MaxWidth   = 4096;
    localparam int MaxHeight  = 4096;
    localparam int SampleBits = 24;
    localparam int CntBits    = 12;
    localparam int CordicN    = 16;
    localparam int SqrtSteps  = 24;
    localparam int DivSteps   = 17;

    // configuration register indexes
    localparam logic [2:0] RegMode   = 3'd0;
    localparam logic [2:0] RegWidth  = 3'd1;
    localparam logic [2:0] RegHeight = 3'd2;
    localparam logic [2:0] RegCx     = 3'd3;
    localparam logic [2:0] RegCy     = 3'd4;
    localparam logic [2:0] RegRadius = 3'd5;
    localparam logic [2:0] RegTaper  = 3'd6;

    localparam logic [16:0] WeightOne = 17'd65536;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIST,
        ST_SQRT,
        ST_DIV,
        ST_ROT,
        ST_SQR,
        ST_OUT
    } t_state;

    // command from sequencer to shared unit
    typedef struct packed {
        logic start_sqrt;
        logic start_div;
        logic start_rot;
    } t_unit_cmd;

    // atan table in q30
    function automatic logic [29:0] atan_q30(input logic [3:0] i);
        case (i)
            4'd0:  atan_q30 = 30'd843314857;
            4'd1:  atan_q30 = 30'd497837829;
            4'd2:  atan_q30 = 30'd263043837;
            4'd3:  atan_q30 = 30'd133525159;
            4'd4:  atan_q30 = 30'd67021687;
            4'd5:  atan_q30 = 30'd33543516;
            4'd6:  atan_q30 = 30'd16775851;
            4'd7:  atan_q30 = 30'd8388437;
            4'd8:  atan_q30 = 30'd4194283;
            4'd9:  atan_q30 = 30'd2097149;
            4'd10: atan_q30 = 30'd1048576;
            4'd11: atan_q30 = 30'd524288;
            4'd12: atan_q30 = 30'd262144;
            4'd13: atan_q30 = 30'd131072;
            4'd14: atan_q30 = 30'd65536;
            default: atan_q30 = 30'd32768;
        endcase
    endfunction

endpackage

// ===== hdl/radial_tukey_mask_apply_unit.sv =====
// top level: raster counters, sequencer and output register of the radial mask
// binary mode compares the distance with the radius; tukey mode runs the square root
// alone when the root decides the weight, else also the divide and cordic (square
// root 24 steps, divide 17 steps, cordic 16 steps on one shared unit); a new beat is
// taken only after the previous result is loaded; a waiting result stalls only the next result
// synchronous active-low reset sets configuration, counters, state and output valid; datapath registers are not reset
module radial_tukey_mask_apply_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [23:0] sample
    input  logic        s_axis_tlast,   // frame_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [23:0] masked_sample, [40:24] mask_value, zero pad
    output logic [1:0]  m_axis_tuser,   // [0] size_error
    output logic        m_axis_tlast    // end_of_frame
);

    logic               r_mode;
    logic [12:0]        r_fw, r_fh;
    logic signed [15:0] r_cx, r_cy;
    logic [15:0]        r_rad;
    logic [16:0]        r_taper;

    logic [11:0]        r_col, r_row;
    logic               r_ovr;

    rtm_pkg::t_state    r_st, n_st;
    logic signed [23:0] r_smp;
    logic               r_last, r_err;
    logic [16:0]        r_w;
    logic [30:0]        r_c;
    logic               r_ov;
    logic [23:0]        r_o_smp;
    logic [16:0]        r_o_w;
    logic               r_o_err, r_o_last;

    rtm_pkg::t_unit_cmd cmd;
    logic               u_done;
    logic [23:0]        u_root;
    logic [16:0]        u_quot;
    logic signed [33:0] u_cos;

    logic [12:0] w_eff, h_eff;
    logic        acc;
    logic        out_load;
    logic signed [17:0] dx, dy;
    logic [35:0] dx2, dy2;
    logic [34:0] d2;
    logic [16:0] a_sat;
    logic [20:0] r_full;
    logic [32:0] inner_p;
    logic [20:0] inner8;
    logic [47:0] ang_p;
    logic [61:0] cc;
    logic [17:0] c2;
    logic signed [40:0] prod;

    // clamped frame size
    always_comb begin
        w_eff = (r_fw == 13'd0) ? 13'd1 : (r_fw > 13'(rtm_pkg::MaxWidth)) ?
                13'(rtm_pkg::MaxWidth) : r_fw;
        h_eff = (r_fh == 13'd0) ? 13'd1 : (r_fh > 13'(rtm_pkg::MaxHeight)) ?
                13'(rtm_pkg::MaxHeight) : r_fh;
    end

    assign s_axis_tready = (r_st == rtm_pkg::ST_IDLE);
    assign acc = s_axis_tvalid && s_axis_tready;
    assign out_load = (r_st == rtm_pkg::ST_OUT) && (!r_ov || m_axis_tready);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0; r_fw <= 13'd64; r_fh <= 13'd64;
            r_cx <= 16'sd512; r_cy <= 16'sd512; r_rad <= 16'd512; r_taper <= 17'd32768;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rtm_pkg::RegMode:   r_mode  <= i_cfg_data[0];
                rtm_pkg::RegWidth:  r_fw    <= i_cfg_data[12:0];
                rtm_pkg::RegHeight: r_fh    <= i_cfg_data[12:0];
                rtm_pkg::RegCx:     r_cx    <= i_cfg_data[15:0];
                rtm_pkg::RegCy:     r_cy    <= i_cfg_data[15:0];
                rtm_pkg::RegRadius: r_rad   <= i_cfg_data[15:0];
                rtm_pkg::RegTaper:  r_taper <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // geometry terms
    always_comb begin
        dx = $signed({2'b0, r_col, 4'b0}) - 18'(r_cx);
        dy = $signed({2'b0, r_row, 4'b0}) - 18'(r_cy);
        a_sat  = (r_taper > rtm_pkg::WeightOne) ? rtm_pkg::WeightOne : r_taper;
        r_full = {1'b0, r_rad, 4'b0};
        inner_p = {1'b0, r_rad} * (rtm_pkg::WeightOne - a_sat);
        inner8 = inner_p[32:12];
        ang_p  = 48'd1686629713 * {31'd0, u_quot};
        cc     = r_c * r_c;
        c2     = cc[61:44];
    end
    assign dx2 = 36'($signed(dx) * $signed(dx));
    assign dy2 = 36'($signed(dy) * $signed(dy));
    assign d2  = 35'(dx2 + dy2);
    assign prod = r_smp * $signed({1'b0, r_w});

    // sequencer next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            rtm_pkg::ST_IDLE: if (acc) n_st = rtm_pkg::ST_DIST;
            rtm_pkg::ST_DIST: n_st = r_mode ? rtm_pkg::ST_SQRT : rtm_pkg::ST_OUT;
            rtm_pkg::ST_SQRT: if (u_done) begin
                if ({1'b0, u_root} <= {4'd0, inner8} || {1'b0, u_root} > {4'd0, r_full})
                    n_st = rtm_pkg::ST_OUT;
                else
                    n_st = rtm_pkg::ST_DIV;
            end
            rtm_pkg::ST_DIV: if (u_done) n_st = rtm_pkg::ST_ROT;
            rtm_pkg::ST_ROT: if (u_done) n_st = rtm_pkg::ST_SQR;
            rtm_pkg::ST_SQR: n_st = rtm_pkg::ST_OUT;
            rtm_pkg::ST_OUT: if (out_load) n_st = rtm_pkg::ST_IDLE;
            default: n_st = rtm_pkg::ST_IDLE;
        endcase
    end

    // unit commands
    always_comb begin
        cmd = '0;
        cmd.start_sqrt = (r_st == rtm_pkg::ST_DIST) && r_mode;
        cmd.start_div  = (r_st == rtm_pkg::ST_SQRT) && (n_st == rtm_pkg::ST_DIV);
        cmd.start_rot  = (r_st == rtm_pkg::ST_DIV) && u_done;
    end

    rtm_iter_unit u_unit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_sqrt_arg ({5'd0, d2, 8'd0}),
        .i_div_num  (21'(u_root) - inner8),
        .i_div_den  (r_full - inner8),
        .i_angle    (ang_p[47:16]),
        .o_done     (u_done),
        .o_root     (u_root),
        .o_quot     (u_quot),
        .o_cos      (u_cos)
    );

    // datapath and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= rtm_pkg::ST_IDLE; r_col <= '0; r_row <= '0; r_ovr <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if (acc) begin
                r_smp  <= s_axis_tdata;
                r_last <= s_axis_tlast;
            end
            if (r_st == rtm_pkg::ST_DIST) begin
                r_w  <= ({1'b0, d2} < 36'({16'd0, r_rad} * {16'd0, r_rad})) ?
                        rtm_pkg::WeightOne : 17'd0;
                r_err <= r_last && (r_ovr || {1'b0, r_col} != w_eff - 13'd1 ||
                         {1'b0, r_row} != h_eff - 13'd1);
                if (r_last) begin
                    r_col <= '0; r_row <= '0; r_ovr <= 1'b0;
                end else if ({1'b0, r_col} + 13'd1 >= w_eff) begin
                    r_col <= '0;
                    if ({1'b0, r_row} + 13'd1 >= h_eff) begin
                        r_row <= '0; r_ovr <= 1'b1;
                    end else r_row <= r_row + 12'd1;
                end else r_col <= r_col + 12'd1;
            end
            if (r_st == rtm_pkg::ST_SQRT && u_done) begin
                r_w <= ({1'b0, u_root} <= {4'd0, inner8}) ? rtm_pkg::WeightOne : 17'd0;
            end
            if (r_st == rtm_pkg::ST_ROT && u_done)
                r_c <= u_cos[33] ? 31'd0 : (u_cos > 34'sd1073741824) ? 31'd1073741824 :
                       u_cos[30:0];
            if (r_st == rtm_pkg::ST_SQR)
                r_w <= (c2 > 18'd65536) ? rtm_pkg::WeightOne : c2[16:0];
            // output register, loaded when empty or as the waiting beat leaves
            if (out_load) begin
                r_o_smp  <= r_err ? 24'd0 : prod[39:16];
                r_o_w    <= r_w;
                r_o_err  <= r_err;
                r_o_last <= r_last;
                r_ov     <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) r_ov <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {7'd0, r_o_w, r_o_smp};
    assign m_axis_tuser  = {1'b0, r_o_err};
    assign m_axis_tlast  = r_o_last;

endmodule

// ===== hdl/rtm_iter_unit.sv =====
// shared iterative unit: square root, restoring divide and cordic rotation steps
module rtm_iter_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rtm_pkg::t_unit_cmd   i_cmd,
    input  logic [47:0]          i_sqrt_arg,
    input  logic [20:0]          i_div_num,
    input  logic [20:0]          i_div_den,
    input  logic [31:0]          i_angle,
    output logic                 o_done,
    output logic [23:0]          o_root,
    output logic [16:0]          o_quot,
    output logic signed [33:0]   o_cos
);

    typedef enum logic [1:0] {U_IDLE, U_SQRT, U_DIV, U_ROT} t_umode;

    t_umode                r_mode, n_mode;
    logic [5:0]            r_cnt, n_cnt;
    logic [47:0]           r_rem, n_rem;
    logic [47:0]           r_res, n_res;
    logic [47:0]           r_bit, n_bit;
    logic signed [33:0]    r_x, n_x, r_y, n_y;
    logic signed [33:0]    r_z, n_z;
    logic [20:0]           r_den, n_den;
    logic                  r_done, n_done;

    logic [48:0]           trial;
    logic [22:0]           dtrial;
    logic signed [33:0]    xs, ys;

    // one step of whichever operation is active
    always_comb begin
        n_mode = r_mode;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_res  = r_res;
        n_bit  = r_bit;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_den  = r_den;
        n_done = 1'b0;
        trial  = {1'b0, r_res} + {1'b0, r_bit};
        dtrial = {1'b0, r_rem[20:0], r_res[16]} - {2'd0, r_den};
        xs     = r_x >>> r_cnt[3:0];
        ys     = r_y >>> r_cnt[3:0];
        case (r_mode)
            U_IDLE: begin
                if (i_cmd.start_sqrt) begin
                    n_mode = U_SQRT;
                    n_rem  = i_sqrt_arg;
                    n_res  = '0;
                    n_bit  = {2'b01, 46'd0};
                    n_cnt  = '0;
                end else if (i_cmd.start_div) begin
                    // quotient fits 17 bits, so the numerator above bit 0 starts as remainder
                    n_mode = U_DIV;
                    n_rem  = {28'd0, i_div_num[20:1]};
                    n_res  = {31'd0, i_div_num[0], 16'd0};
                    n_den  = i_div_den;
                    n_cnt  = '0;
                end else if (i_cmd.start_rot) begin
                    n_mode = U_ROT;
                    n_x    = 34'sd652032874;
                    n_y    = '0;
                    n_z    = $signed({2'b00, i_angle});
                    n_cnt  = '0;
                end
            end
            U_SQRT: begin
                if (r_rem >= trial[47:0] && !trial[48]) begin
                    n_rem = r_rem - trial[47:0];
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(rtm_pkg::SqrtSteps - 1)) begin
                    n_mode = U_IDLE;
                    n_done = 1'b1;
                end
            end
            U_DIV: begin
                // restoring divide, numerator bits leave the top of the 17-bit field
                // while quotient bits enter at the bottom
                n_res = {31'd0, r_res[15:0], ~dtrial[22]};
                if (!dtrial[22]) begin
                    n_rem = {26'd0, dtrial[21:0]};
                end else begin
                    n_rem = {26'd0, r_rem[20:0], r_res[16]};
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(rtm_pkg::DivSteps - 1)) begin
                    n_mode = U_IDLE;
                    n_done = 1'b1;
                end
            end
            default: begin
                if (!r_z[33]) begin
                    n_x = r_x - ys;
                    n_y = r_y + xs;
                    n_z = r_z - $signed({4'd0, rtm_pkg::atan_q30(r_cnt[3:0])});
                end else begin
                    n_x = r_x + ys;
                    n_y = r_y - xs;
                    n_z = r_z + $signed({4'd0, rtm_pkg::atan_q30(r_cnt[3:0])});
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(rtm_pkg::CordicN - 1)) begin
                    n_mode = U_IDLE;
                    n_done = 1'b1;
                end
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= U_IDLE;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_mode <= n_mode;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_res <= n_res;
        r_bit <= n_bit;
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_root = r_res[23:0];
    assign o_quot = r_res[16:0];
    assign o_cos  = r_x;

endmodule

// ===== hdl/rtm_checker.sv =====
// port-level checks for the radial mask unit
module rtm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    // input not ready while the accepted beat is worked on
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("accept while busy");
    // size error forces zero sample
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[23:0] == 24'd0))
        else $error("error beat not zero");
    // weight within one
    a_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[40:24] <= 17'd65536)) else $error("weight range");
    // stalled output holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output dropped");
endmodule

bind radial_tukey_mask_apply_unit rtm_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
